// ----- design/iqcm_pkg.sv -----
// Shared types, codes and carrier table helpers for the IQ carrier mixer.
`timescale 1ns / 1ps

package iqcm_pkg;

	// Configuration register indexes
	localparam int CFG_ADDR_BITS = 1;
	localparam int CFG_DATA_BITS = 32;
	localparam logic [CFG_ADDR_BITS-1:0] REG_PHASE_STEP = 1'b0;
	localparam logic [CFG_ADDR_BITS-1:0] REG_MODE       = 1'b1;

	// Mixer mode codes
	typedef enum logic {
		MODE_DEMOD = 1'b0,
		MODE_MOD   = 1'b1
	} mix_mode_t;

	localparam int PHASE_BITS = 32;

	// Q2.30 constants for the carrier table
	localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] SQRT2_Q30   = 64'd1518500250;

	// One Horner step: 1 - q, clamped at zero
	function automatic logic [63:0] clamp_sub(input logic [63:0] q);
		return (q >= ONE_Q30) ? 64'd0 : ONE_Q30 - q;
	endfunction

	// Angle of a quarter-wave entry in Q2.30
	function automatic logic [63:0] angle_q30(input int unsigned r, input int unsigned qb);
		return (64'(r) * HALF_PI_Q30) >> qb;
	endfunction

	// Quarter-wave sine in Q2.30, Taylor series to x^11
	function automatic logic [30:0] quarter_sin(input int unsigned r, input int unsigned qb);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] sv;
		x  = angle_q30(r, qb);
		x2 = (x * x) >> 30;
		t  = ONE_Q30;
		t  = clamp_sub(((x2 * t) >> 30) / 64'd110);
		t  = clamp_sub(((x2 * t) >> 30) / 64'd72);
		t  = clamp_sub(((x2 * t) >> 30) / 64'd42);
		t  = clamp_sub(((x2 * t) >> 30) / 64'd20);
		t  = clamp_sub(((x2 * t) >> 30) / 64'd6);
		sv = (x * t) >> 30;
		if (sv > ONE_Q30) begin
			sv = ONE_Q30;
		end
		return 31'(sv);
	endfunction

	// Quarter-wave cosine in Q2.30, Taylor series to x^12
	function automatic logic [30:0] quarter_cos(input int unsigned r, input int unsigned qb);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		x  = angle_q30(r, qb);
		x2 = (x * x) >> 30;
		t  = ONE_Q30;
		t  = clamp_sub(((x2 * t) >> 30) / 64'd132);
		t  = clamp_sub(((x2 * t) >> 30) / 64'd90);
		t  = clamp_sub(((x2 * t) >> 30) / 64'd56);
		t  = clamp_sub(((x2 * t) >> 30) / 64'd30);
		t  = clamp_sub(((x2 * t) >> 30) / 64'd12);
		t  = clamp_sub(((x2 * t) >> 30) / 64'd2);
		return 31'(t);
	endfunction

	// Scale a non-negative Q2.30 value by sqrt(2), rounded to nearest
	function automatic logic [30:0] scale_sqrt2(input logic [30:0] v);
		return 31'((64'(v) * SQRT2_Q30 + (64'd1 << 29)) >> 30);
	endfunction

endpackage

// ----- design/iq_carrier_mixer.sv -----
// NCO-driven IQ mixer: phase accumulator, sine/cosine table, mixing and saturation.
//
// Channel  | Group   | Payload (lowest bits first)
// ---------+---------+-----------------------------------------------
// input    | s_axis  | tdata: in_real, in_imag; tuser: block_start
// output   | m_axis  | tdata: out_real, out_imag; tuser: saturated
// config   | cfg     | cfg_addr 0 phase_step, 1 mode; cfg_wdata
//
// One sample per cycle sustained while m_tready is high; between input request and
// result lie the input register, carrier lookup, product register and result register.
// The sine/cosine table is constant logic built at elaboration.
// arst_n clears the phase, the configuration registers and all stage valids.
// A stalled output fills the empty stages first; s_tready drops once all are full.
`timescale 1ns / 1ps

module iq_carrier_mixer #(
	parameter int TABLE_ADDR_BITS = 10,
	parameter int SAMPLE_BITS     = 16
) (
	input  logic clk,
	input  logic arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [iqcm_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
	input  logic [iqcm_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,  // in_real, in_imag
	input  logic                                s_tuser,  // block_start
	// output stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  m_tdata,  // out_real, out_imag
	output logic                                m_tuser   // saturated
);

	localparam int DW     = ((2*SAMPLE_BITS+7)/8)*8;
	localparam int QB     = TABLE_ADDR_BITS - 2;
	localparam int QDEPTH = 1 << QB;
	localparam int CW     = 32;                    // signed carrier width
	localparam int PW     = SAMPLE_BITS + CW;      // product width
	localparam int AW     = PW + 1;                // sum width
	localparam int RW     = SAMPLE_BITS + 3;       // rounded result width

	localparam logic signed [AW-1:0] HALF29 = AW'(1) <<< 28;
	localparam logic signed [AW-1:0] HALF30 = AW'(1) <<< 29;
	localparam logic signed [RW-1:0] SAT_HI = RW'((1 << (SAMPLE_BITS-1)) - 1);
	localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

	// Configuration registers
	logic [iqcm_pkg::PHASE_BITS-1:0] step_q;
	iqcm_pkg::mix_mode_t             mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			mode_q <= iqcm_pkg::MODE_DEMOD;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				iqcm_pkg::REG_PHASE_STEP: step_q <= cfg_wdata[iqcm_pkg::PHASE_BITS-1:0];
				iqcm_pkg::REG_MODE:       mode_q <= iqcm_pkg::mix_mode_t'(cfg_wdata[0]);
				default: ;
			endcase
		end
	end

	// Stage enables: a stage advances when it is empty or its successor advances
	logic v1_s1, v2_s2, v3_s3, v4_s4;
	logic en1, en2, en3, en4;
	logic accept;

	assign en4      = !v4_s4 || m_tready;
	assign en3      = !v3_s3 || en4;
	assign en2      = !v2_s2 || en3;
	assign en1      = !v1_s1 || en2;
	assign s_tready = en1;
	assign accept   = s_tvalid && en1;
	assign m_tvalid = v4_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else begin
			if (en1) v1_s1 <= s_tvalid;
			if (en2) v2_s2 <= v1_s1;
			if (en3) v3_s3 <= v2_s2;
			if (en4) v4_s4 <= v3_s3;
		end
	end

	// Phase accumulator: clear on block start, step once per accepted request
	logic [iqcm_pkg::PHASE_BITS-1:0] phase_q;
	logic [iqcm_pkg::PHASE_BITS-1:0] phase_use;

	assign phase_use = s_tuser ? '0 : phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (accept) begin
			phase_q <= phase_use + step_q;
		end
	end

	// Stage 1: capture samples and table address
	logic        [TABLE_ADDR_BITS-1:0] addr_s1;
	logic signed [SAMPLE_BITS-1:0]     re_s1;
	logic signed [SAMPLE_BITS-1:0]     im_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= phase_use[iqcm_pkg::PHASE_BITS-1 -: TABLE_ADDR_BITS];
			re_s1   <= s_tdata[SAMPLE_BITS-1:0];
			im_s1   <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
		end
	end

	// Quarter-wave tables, plain and scaled by sqrt(2)
	logic [30:0] cos_tab  [QDEPTH];
	logic [30:0] sin_tab  [QDEPTH];
	logic [30:0] kcos_tab [QDEPTH];
	logic [30:0] ksin_tab [QDEPTH];

	for (genvar r = 0; r < QDEPTH; r++) begin : g_tab
		assign cos_tab[r]  = iqcm_pkg::quarter_cos(r, QB);
		assign sin_tab[r]  = iqcm_pkg::quarter_sin(r, QB);
		assign kcos_tab[r] = iqcm_pkg::scale_sqrt2(iqcm_pkg::quarter_cos(r, QB));
		assign ksin_tab[r] = iqcm_pkg::scale_sqrt2(iqcm_pkg::quarter_sin(r, QB));
	end

	// Stage 2: look up carrier, apply quadrant symmetry, pick multiplicands
	logic        [1:0]    quad;
	logic        [QB-1:0] ridx;
	logic signed [CW-1:0] ci, si, kci, ksi;
	logic signed [CW-1:0] c_val, s_val, kc_val, ks_val;
	logic signed [CW-1:0] op_a_s2, op_b_s2;
	logic signed [SAMPLE_BITS-1:0] re_s2, xb_s2;

	assign quad = addr_s1[TABLE_ADDR_BITS-1 -: 2];
	assign ridx = addr_s1[QB-1:0];
	assign ci   = signed'({1'b0, cos_tab[ridx]});
	assign si   = signed'({1'b0, sin_tab[ridx]});
	assign kci  = signed'({1'b0, kcos_tab[ridx]});
	assign ksi  = signed'({1'b0, ksin_tab[ridx]});

	always_comb begin
		case (quad)
			2'd0: begin
				c_val = ci;   s_val = si;   kc_val = kci;  ks_val = ksi;
			end
			2'd1: begin
				c_val = -si;  s_val = ci;   kc_val = -ksi; ks_val = kci;
			end
			2'd2: begin
				c_val = -ci;  s_val = -si;  kc_val = -kci; ks_val = -ksi;
			end
			default: begin
				c_val = si;   s_val = -ci;  kc_val = ksi;  ks_val = -kci;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			re_s2   <= re_s1;
			op_a_s2 <= (mode_q == iqcm_pkg::MODE_MOD) ? c_val : kc_val;
			op_b_s2 <= (mode_q == iqcm_pkg::MODE_MOD) ? s_val : ks_val;
			xb_s2   <= (mode_q == iqcm_pkg::MODE_MOD) ? im_s1 : re_s1;
		end
	end

	// Stage 3: multiply samples by carrier
	logic signed [PW-1:0] p0_s3, p1_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			p0_s3 <= PW'(re_s2) * PW'(op_a_s2);
			p1_s3 <= PW'(xb_s2) * PW'(op_b_s2);
		end
	end

	// Stage 4: sum the products in modulation mode, round half away from zero, saturate
	logic signed [AW-1:0] ext0, ext1, sum;
	logic signed [AW-1:0] t0, t1;
	logic signed [AW-1:0] q0, q1;
	logic signed [RW-1:0] r0, r1;
	logic signed [SAMPLE_BITS-1:0] out_re, out_im;
	logic clip;

	assign ext0 = AW'(p0_s3);
	assign ext1 = AW'(p1_s3);
	assign sum  = ext0 + ext1;

	always_comb begin
		if (mode_q == iqcm_pkg::MODE_MOD) begin
			t0 = sum + (sum[AW-1] ? HALF29 - AW'(1) : HALF29);
			t1 = '0;
			q0 = t0 >>> 29;
			q1 = '0;
		end else begin
			t0 = ext0 + (ext0[AW-1] ? HALF30 - AW'(1) : HALF30);
			t1 = ext1 + (ext1[AW-1] ? HALF30 - AW'(1) : HALF30);
			q0 = t0 >>> 30;
			q1 = t1 >>> 30;
		end
		r0   = q0[RW-1:0];
		r1   = q1[RW-1:0];
		clip = 1'b0;
		if (r0 > SAT_HI) begin
			out_re = SAT_HI[SAMPLE_BITS-1:0];
			clip   = 1'b1;
		end else if (r0 < SAT_LO) begin
			out_re = SAT_LO[SAMPLE_BITS-1:0];
			clip   = 1'b1;
		end else begin
			out_re = r0[SAMPLE_BITS-1:0];
		end
		if (r1 > SAT_HI) begin
			out_im = SAT_HI[SAMPLE_BITS-1:0];
			clip   = 1'b1;
		end else if (r1 < SAT_LO) begin
			out_im = SAT_LO[SAMPLE_BITS-1:0];
			clip   = 1'b1;
		end else begin
			out_im = r1[SAMPLE_BITS-1:0];
		end
	end

	// Result register: hold while the output request waits
	logic [SAMPLE_BITS-1:0] real_s4, imag_s4;
	logic                   sat_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			real_s4 <= out_re;
			imag_s4 <= out_im;
			sat_s4  <= clip;
		end
	end

	assign m_tdata = DW'({imag_s4, real_s4});
	assign m_tuser = sat_s4;

endmodule
